[design/fnvlp_pkg.sv]
package fnvlp_pkg;

   localparam int TableDepthDefault = 16;
   localparam int KeyBytesDefault   = 8;
   localparam int ValueBitsDefault  = 32;

   localparam logic [31:0] FnvBasis = 32'd2166136261;
   localparam logic [31:0] FnvMult  = 32'd16777619;
   localparam int LoadNum = 3;
   localparam int LoadDen = 4;

   localparam logic [1:0] ModeInsert = 2'd0;
   localparam logic [1:0] ModeLookup = 2'd1;
   localparam logic [1:0] ModeRemove = 2'd2;

   localparam logic [1:0] StatusDone    = 2'd0;
   localparam logic [1:0] StatusMissing = 2'd1;
   localparam logic [1:0] StatusFull    = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key;
      logic [3:0]  key_length;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [4:0]  occupancy;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key;
      logic [3:0]  key_length;
      logic [31:0] value;
      logic [31:0] hash;
   } job_type;

endpackage

[design/fnvlp_front.sv]
module fnvlp_front
   import fnvlp_pkg::*;
#(
   parameter int KEY_BYTES = KeyBytesDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_stall,
   output job_type job_data
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   job_type     job_ff, job_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] h_x;
   logic [3:0]  len_sat;
   logic [63:0] mask;

   // saturate length and mask unused bytes
   always_comb begin
      len_sat = (req_data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_data.key_length;
      for (int i = 0; i < 8; i++) begin
         mask[i*8 +: 8] = (4'(i) < len_sat) ? 8'hff : 8'h00;
      end
   end

   assign req_stall = busy_ff;
   assign job_valid = done_ff;
   assign job_data  = job_ff;
   assign h_x = job_ff.hash ^ {24'd0, job_ff.key[cnt_ff[2:0]*8 +: 8]};

   // one hash byte per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      job_in  = job_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff && req_valid) begin
         busy_in           = 1'b1;
         job_in.mode       = req_data.mode;
         job_in.key        = req_data.key & mask;
         job_in.key_length = len_sat;
         job_in.value      = req_data.value;
         job_in.hash       = FnvBasis;
         cnt_in            = 4'd0;
      end else if (busy_ff && !done_ff) begin
         if (cnt_ff < job_ff.key_length) begin
            job_in.hash = h_x * FnvMult;
            cnt_in      = cnt_ff + 4'd1;
         end else begin
            done_in = 1'b1;
         end
      end else if (done_ff && !job_stall) begin
         done_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      job_ff <= job_in;
   end

endmodule

[design/fnvlp_queue.sv]
module fnvlp_queue
   import fnvlp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_data
);

   job_type    mem_ff [2];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic       push, pop;

   // two-entry fifo between front and back
   assign in_stall  = (wr_ff[1] != rd_ff[1]) && (wr_ff[0] == rd_ff[0]);
   assign out_valid = wr_ff != rd_ff;
   assign out_data  = mem_ff[rd_ff[0]];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;
   assign wr_in = push ? wr_ff + 2'd1 : wr_ff;
   assign rd_in = pop ? rd_ff + 2'd1 : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 2'd0;
         rd_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push) begin
         mem_ff[wr_ff[0]] <= in_data;
      end
   end

endmodule

[design/fnvlp_back.sv]
module fnvlp_back
   import fnvlp_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int VALUE_BITS  = ValueBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_stall,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IdxW   = $clog2(TABLE_DEPTH);
   localparam int CntW   = $clog2(TABLE_DEPTH + 1);
   localparam int Thresh = (TABLE_DEPTH * LoadNum) / LoadDen;

   typedef enum logic [1:0] {Idle, Read, Check, Reply} state_type;

   state_type         state_ff;
   job_type           job_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [CntW-1:0]   n_ff;
   logic [CntW-1:0]   count_ff;
   logic [TABLE_DEPTH-1:0] occ_ff;
   logic [63:0]       key_mem [TABLE_DEPTH];
   logic [3:0]        len_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
   logic [63:0]       rd_key_ff;
   logic [3:0]        rd_len_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic              rd_occ_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic [1:0]        status_ff;
   logic [31:0]       found_ff;
   logic              hit;
   logic [VALUE_BITS-1:0] wval;
   logic [63:0]       wide_val;

   assign job_stall = state_ff != Idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign hit = rd_occ_ff && rd_len_ff == job_ff.key_length && rd_key_ff == job_ff.key;
   assign wide_val = {32'd0, job_ff.value};
   assign wval = wide_val[VALUE_BITS-1:0];

   // slot memory read, registered
   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[idx_ff];
      rd_len_ff <= len_mem[idx_ff];
      rd_val_ff <= val_mem[idx_ff];
      rd_occ_ff <= occ_ff[idx_ff];
      if (state_ff == Check && job_ff.mode == ModeInsert && !rd_occ_ff) begin
         key_mem[idx_ff] <= job_ff.key;
         len_mem[idx_ff] <= job_ff.key_length;
         val_mem[idx_ff] <= wval;
      end else if (state_ff == Check && job_ff.mode == ModeInsert && hit) begin
         val_mem[idx_ff] <= wval;
      end
   end

   // probe walk sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= Idle;
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         n_ff         <= '0;
      end else begin
         // result valid: set on reply, cleared once taken
         if (state_ff == Reply && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            Idle: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  idx_ff   <= job_data.hash[IdxW-1:0];
                  n_ff     <= '0;
                  found_ff <= 32'd0;
                  if (job_data.mode == ModeInsert) begin
                     if (count_ff >= CntW'(Thresh)) begin
                        status_ff <= StatusFull;
                        state_ff  <= Reply;
                     end else begin
                        state_ff <= Read;
                     end
                  end else if (job_data.mode == ModeLookup || job_data.mode == ModeRemove) begin
                     state_ff <= Read;
                  end else begin
                     status_ff <= StatusDone;
                     state_ff  <= Reply;
                  end
               end
            end
            Read: begin
               state_ff <= Check;
            end
            Check: begin
               if (job_ff.mode == ModeInsert && (!rd_occ_ff || hit)) begin
                  status_ff <= StatusDone;
                  if (!rd_occ_ff) begin
                     occ_ff[idx_ff] <= 1'b1;
                     count_ff       <= count_ff + 1'b1;
                  end
                  state_ff <= Reply;
               end else if (job_ff.mode != ModeInsert && hit) begin
                  status_ff <= StatusDone;
                  if (job_ff.mode == ModeLookup) begin
                     found_ff <= 32'(rd_val_ff);
                  end else begin
                     occ_ff[idx_ff] <= 1'b0;
                     count_ff       <= count_ff - 1'b1;
                  end
                  state_ff <= Reply;
               end else if (n_ff == CntW'(TABLE_DEPTH - 1)) begin
                  status_ff <= (job_ff.mode == ModeInsert) ? StatusFull : StatusMissing;
                  state_ff  <= Reply;
               end else begin
                  n_ff     <= n_ff + 1'b1;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= Read;
               end
            end
            Reply: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.status      <= status_ff;
                  rsp_ff.found_value <= found_ff;
                  rsp_ff.occupancy   <= 5'(count_ff);
                  state_ff           <= Idle;
               end
            end
            default: state_ff <= Idle;
         endcase
      end
   end

endmodule

[design/fnv_linear_probe_hash_table_top.sv]
// Key/value table with open addressing: the home slot is the FNV-1a hash of the key modulo
// TABLE_DEPTH (a power of two), collisions walk linearly. A front stage hashes one key byte
// per cycle, a two-entry queue decouples it from the back stage, which walks the slot memory
// with a Read and a Check state per probed slot (one memory read port), up to TABLE_DEPTH
// slots, between its Idle and Reply states. Inserts are refused with status full at three
// quarters load.
module fnv_linear_probe_hash_table_top
   import fnvlp_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int KEY_BYTES   = KeyBytesDefault,
   parameter int VALUE_BITS  = ValueBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    f_valid, f_stall, b_valid, b_stall;
   job_type f_data, b_data;

   fnvlp_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid(f_valid), .job_stall(f_stall), .job_data(f_data)
   );

   fnvlp_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   fnvlp_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_stall(b_stall), .job_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
   import fnvlp_pkg::*;

   localparam int Depth = TableDepthDefault;
   localparam int LoadLimit = (Depth * LoadNum) / LoadDen;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // predicted table contents
   logic [63:0] tbl_key [Depth];
   logic [3:0]  tbl_len [Depth];
   logic [31:0] tbl_val [Depth];
   logic        tbl_used [Depth];
   int          tbl_count;

   rsp_type expected_rsps[$];
   int      error_count;
   bit      idle_enable;
   bit      hold_off;
   int      hold_cycles;
   logic [63:0] key_pool [8];
   logic [3:0]  len_pool [8];

   fnv_linear_probe_hash_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [31:0] fnv_hash(logic [63:0] k, int n);
      logic [31:0] h;
      h = FnvBasis;
      for (int i = 0; i < n; i++) begin
         h = h ^ {24'd0, k[8*i +: 8]};
         h = h * FnvMult;
      end
      return h;
   endfunction

   // update the predicted table and return the expected response
   function automatic rsp_type table_apply(req_type r);
      rsp_type     o;
      int          n;
      int          idx;
      logic [63:0] k;
      logic [31:0] h;
      n = (r.key_length > KeyBytesDefault) ? KeyBytesDefault : r.key_length;
      k = (n >= 8) ? r.key : (r.key & ((64'd1 << (8 * n)) - 64'd1));
      h = fnv_hash(k, n);
      idx = h % Depth;
      o = '0;
      if (r.mode == ModeInsert) begin
         o.status = StatusFull;
         if (tbl_count < LoadLimit) begin
            for (int s = 0; s < Depth; s++) begin
               if (!tbl_used[idx]) begin
                  tbl_used[idx] = 1'b1;
                  tbl_key[idx] = k;
                  tbl_len[idx] = 4'(n);
                  tbl_val[idx] = r.value;
                  tbl_count++;
                  o.status = StatusDone;
                  break;
               end
               if (tbl_len[idx] == n && tbl_key[idx] == k) begin
                  tbl_val[idx] = r.value;
                  o.status = StatusDone;
                  break;
               end
               idx = (idx + 1) % Depth;
            end
         end
      end else if (r.mode == ModeLookup || r.mode == ModeRemove) begin
         o.status = StatusMissing;
         for (int s = 0; s < Depth; s++) begin
            if (tbl_used[idx] && tbl_len[idx] == n && tbl_key[idx] == k) begin
               o.status = StatusDone;
               if (r.mode == ModeLookup) begin
                  o.found_value = tbl_val[idx];
               end else begin
                  tbl_used[idx] = 1'b0;
                  tbl_count--;
               end
               break;
            end
            idx = (idx + 1) % Depth;
         end
      end
      o.occupancy = 5'(tbl_count);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // send one transaction, with random gaps
   task automatic send_req(logic [1:0] m, logic [63:0] k, logic [3:0] n, logic [31:0] v);
      req_type r;
      while (idle_enable && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      r.mode = m;
      r.key = k;
      r.key_length = n;
      r.value = v;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(table_apply(r));
   endtask

   // response stall: random, or a long counted hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_cycles <= 300;
         hold_off <= 1'b0;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(99) < 30);
      end
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.status, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.found_value != want.found_value)
               report_mismatch("found_value", rsp_data.found_value, want.found_value);
            if (rsp_data.occupancy != want.occupancy)
               report_mismatch("occupancy", rsp_data.occupancy, want.occupancy);
         end
      end
   end

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // extremes, every kind, zero and oversize lengths, mode 3, full table
   task automatic test_directed();
      send_req(ModeLookup, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(ModeInsert, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
      send_req(ModeLookup, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(ModeInsert, 64'hAB, 4'd0, 32'h1234);
      send_req(ModeLookup, 64'h0, 4'd0, 32'd0);
      send_req(ModeInsert, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
      send_req(ModeLookup, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
      send_req(ModeInsert, 64'hFFFF_FFFF_FFFF_FF01, 4'd1, 32'h5555);
      send_req(ModeLookup, 64'h01, 4'd2, 32'd0);
      send_req(2'd3, 64'h01, 4'd1, 32'hFFFF_FFFF);
      send_req(ModeRemove, 64'h01, 4'd1, 32'd0);
      send_req(ModeRemove, 64'h01, 4'd1, 32'd0);
      for (int i = 0; i < 13; i++)
         send_req(ModeInsert, 64'(i * 64'h0101_0101 + 7), 4'd4, i);
   endtask

   // a small pool of keys keeps hits, collisions, holes and full frequent
   task automatic test_random(int count);
      logic [63:0] k;
      logic [3:0]  n;
      int          p;
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) idle_enable = 1'b0;
         if (i == count / 2) idle_enable = 1'b1;
         if ($urandom_range(99) < 80) begin
            p = $urandom_range(7);
            k = key_pool[p];
            n = len_pool[p];
         end else begin
            k = {$urandom, $urandom};
            n = 4'($urandom_range(15));
         end
         send_req($urandom_range(3) == 3 ? 2'd3 : 2'($urandom_range(2)), k, n, $urandom);
         if ($urandom_range(99) < 3) begin
            for (int j = 0; j < 8; j++) send_req(ModeRemove, key_pool[j], len_pool[j], 0);
         end
      end
   endtask

   // long response hold-off while requests keep coming
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++)
         send_req(2'($urandom_range(2)), key_pool[i % 8], len_pool[i % 8], $urandom);
   endtask

   initial begin
      error_count = 0;
      idle_enable = 1'b1;
      hold_off = 1'b0;
      hold_cycles = 0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      tbl_count = 0;
      for (int i = 0; i < Depth; i++) tbl_used[i] = 1'b0;
      for (int i = 0; i < 8; i++) begin
         key_pool[i] = {$urandom, $urandom};
         len_pool[i] = 4'($urandom_range(8));
      end
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(460);
      wait_drain();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("** fnv_linear_probe_hash_table_top: PASSED **");
      end else begin
         $display("** fnv_linear_probe_hash_table_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** fnv_linear_probe_hash_table_top: FAILED **");
      $finish;
   end

endmodule

[files.f]
design/fnvlp_pkg.sv
design/fnvlp_front.sv
design/fnvlp_queue.sv
design/fnvlp_back.sv
design/fnv_linear_probe_hash_table_top.sv
sim/tb.sv
